// ===== design/asgd_pkg.sv =====
// package: widths, register indexes and reset values of the swing gesture detector
`timescale 1ns / 1ps
package asgd_pkg;

  // default window geometry
  localparam int WINDOW_DEF      = 15;
  localparam int SAMPLE_BITS_DEF = 10;

  // fixed field widths
  localparam int THR_W  = 10;
  localparam int CNT_W  = 8;
  localparam int BTN_W  = 11;
  localparam int CODE_W = 3;
  localparam int LED_W  = 4;
  localparam int AXES   = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWING_THRESHOLD = 2'd0,
    REG_HOLD_TICKS      = 2'd1,
    REG_BLINK_TICKS     = 2'd2
  } cfg_reg_t;

  // reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST  = THR_W'(180);
  localparam logic [CNT_W-1:0] HOLD_RST       = CNT_W'(15);
  localparam logic [CNT_W-1:0] BLINK_RST      = CNT_W'(45);
  localparam logic [CNT_W-1:0] BLINK_CNT_RST  = CNT_W'(15);
  localparam logic [CNT_W-1:0] COUNT_MAX      = CNT_W'(255);
  localparam logic [LED_W-1:0] IDLE_LED       = LED_W'(8);

endpackage

// ===== design/asgd_in_if.sv =====
// interface: sample word channel (three axes and the button mask)
`timescale 1ns / 1ps
interface asgd_in_if #(
  parameter int SAMPLE_BITS = asgd_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [SAMPLE_BITS-1:0]      accel_x;
  logic [SAMPLE_BITS-1:0]      accel_y;
  logic [SAMPLE_BITS-1:0]      accel_z;
  logic [asgd_pkg::BTN_W-1:0]  button_mask;

  modport source (output valid, accel_x, accel_y, accel_z, button_mask, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, button_mask, output ready);
endinterface

// ===== design/asgd_out_if.sv =====
// interface: result word channel
`timescale 1ns / 1ps
interface asgd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         gesture_seen;
  logic                         gesture_event;
  logic [asgd_pkg::CODE_W-1:0]  gesture_code;
  logic [asgd_pkg::LED_W-1:0]   indicator_leds;
  logic                         button_event;
  logic [asgd_pkg::BTN_W-1:0]   buttons_now;

  modport source (output valid, gesture_seen, gesture_event, gesture_code, indicator_leds,
                  button_event, buttons_now, input ready);
  modport sink   (input valid, gesture_seen, gesture_event, gesture_code, indicator_leds,
                  button_event, buttons_now, output ready);
endinterface

// ===== design/asgd_cfg_if.sv =====
// interface: configuration register write channel
`timescale 1ns / 1ps
interface asgd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [asgd_pkg::CFG_IDX_W-1:0]   index;
  logic [asgd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/accel_swing_gesture_detector.sv =====
// top level: swing gesture detector with the sample window in a circular memory
// flow: each accepted word is shifted into the window, the window is scanned from its
//   scan start s to entry WINDOW-1 and the result word is registered; s is one less than
//   the scan start left by the previous word, or 0 when that was 0 (0 after reset)
// a new word is accepted only once the previous word's result has entered the output
//   register; the window memory read port reads one entry per cycle during the scan
// reset: control state cleared; only the first word after reset writes all WINDOW entries
`timescale 1ns / 1ps
module accel_swing_gesture_detector #(
  parameter int WINDOW      = asgd_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = asgd_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  asgd_in_if.sink     smp,
  asgd_out_if.source  res,
  asgd_cfg_if.sink    cfg
);

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SB     = SAMPLE_BITS;
  localparam int WORD_W = asgd_pkg::AXES * SB;
  localparam int CMP_W  = (SB > asgd_pkg::THR_W) ? SB : asgd_pkg::THR_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FILL  = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_LAST  = 6'b010000,
    ST_EVAL  = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic [asgd_pkg::THR_W-1:0] swing_threshold;
  logic [asgd_pkg::CNT_W-1:0] hold_ticks;
  logic [asgd_pkg::CNT_W-1:0] blink_ticks;

  // tick state
  logic                        window_primed;
  logic [IDX_W-1:0]            head;
  logic [IDX_W-1:0]            fill_cnt;
  logic [IDX_W-1:0]            scan_start;
  logic [SB-1:0]               peak_swing;
  logic                        gesture_held;
  logic [asgd_pkg::CODE_W-1:0] held_code;
  logic [asgd_pkg::CNT_W-1:0]  ticks_since_gesture;
  logic [asgd_pkg::CNT_W-1:0]  ticks_since_blink;
  logic                        blink_level;
  logic [asgd_pkg::LED_W-1:0]  led_pattern;
  logic [asgd_pkg::BTN_W-1:0]  prior_buttons;

  // latched word
  logic [WORD_W-1:0]           smp_word;
  logic [asgd_pkg::BTN_W-1:0]  smp_buttons;

  // window memory
  logic [WORD_W-1:0] win_mem [WINDOW];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_pos;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W:0]    addr_sum;

  // per-axis extremes
  logic [SB:0]       lo     [asgd_pkg::AXES];
  logic [SB-1:0]     hi     [asgd_pkg::AXES];
  logic [IDX_W-1:0]  lo_pos [asgd_pkg::AXES];
  logic [IDX_W-1:0]  hi_pos [asgd_pkg::AXES];

  // evaluation
  logic [SB-1:0]               mag  [asgd_pkg::AXES];
  logic                        neg  [asgd_pkg::AXES];
  logic [IDX_W-1:0]            epos [asgd_pkg::AXES];
  logic [1:0]                  best;
  logic                        seen;
  logic                        event_flag;
  logic [asgd_pkg::CODE_W-1:0] code;
  logic                        eval_go;

  logic [asgd_pkg::LED_W-1:0]  led_pattern_next;
  logic                        gesture_held_next;
  logic                        blink_level_next;
  logic [asgd_pkg::CNT_W-1:0]  ticks_since_gesture_next;
  logic [asgd_pkg::CNT_W-1:0]  ticks_since_blink_next;
  logic                        blink_reload;

  // output register
  logic                        res_valid;
  logic                        res_seen;
  logic                        res_event;
  logic [asgd_pkg::CODE_W-1:0] res_code;
  logic [asgd_pkg::LED_W-1:0]  res_leds;
  logic                        res_bev;
  logic [asgd_pkg::BTN_W-1:0]  res_buttons;

  assign smp.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid          = res_valid;
  assign res.gesture_seen   = res_seen;
  assign res.gesture_event  = res_event;
  assign res.gesture_code   = res_code;
  assign res.indicator_leds = res_leds;
  assign res.button_event   = res_bev;
  assign res.buttons_now    = res_buttons;

  assign eval_go = (state == ST_EVAL) && (!res_valid || res.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      swing_threshold <= asgd_pkg::THRESHOLD_RST;
      hold_ticks      <= asgd_pkg::HOLD_RST;
      blink_ticks     <= asgd_pkg::BLINK_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        asgd_pkg::REG_SWING_THRESHOLD: swing_threshold <= cfg.data[asgd_pkg::THR_W-1:0];
        asgd_pkg::REG_HOLD_TICKS:      hold_ticks      <= cfg.data[asgd_pkg::CNT_W-1:0];
        asgd_pkg::REG_BLINK_TICKS:     blink_ticks     <= cfg.data[asgd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // logical window index to physical address
  always_comb begin
    addr_sum = {1'b0, head} + {1'b0, rd_idx};
    if (addr_sum >= (IDX_W + 1)'(WINDOW)) begin
      addr_sum = addr_sum - (IDX_W + 1)'(WINDOW);
    end
    rd_addr   = addr_sum[IDX_W-1:0];
    mem_we    = (state == ST_FILL) || (state == ST_SHIFT);
    mem_waddr = (state == ST_FILL) ? fill_cnt : head;
  end

  // window memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= smp_word;
    end
    rd_data <= win_mem[rd_addr];
  end

  // read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
    end
    rd_pos <= rd_idx;
  end

  // min/max tracking over the scan
  always_ff @(posedge clk) begin
    for (int a = 0; a < asgd_pkg::AXES; a++) begin
      if (state == ST_SHIFT) begin
        lo[a]     <= (SB + 1)'(1) << SB;
        hi[a]     <= '0;
        lo_pos[a] <= '0;
        hi_pos[a] <= '0;
      end else if (rd_vld) begin
        if ({1'b0, rd_data[a*SB +: SB]} < lo[a]) begin
          lo[a]     <= {1'b0, rd_data[a*SB +: SB]};
          lo_pos[a] <= rd_pos;
        end
        if (rd_data[a*SB +: SB] > hi[a]) begin
          hi[a]     <= rd_data[a*SB +: SB];
          hi_pos[a] <= rd_pos;
        end
      end
    end
  end

  // swing per axis and the strongest axis
  always_comb begin
    for (int a = 0; a < asgd_pkg::AXES; a++) begin
      mag[a] = hi[a] - lo[a][SB-1:0];
      if (lo_pos[a] <= hi_pos[a]) begin
        neg[a]  = 1'b0;
        epos[a] = hi_pos[a];
      end else begin
        neg[a]  = (hi[a] != lo[a][SB-1:0]);
        epos[a] = lo_pos[a];
      end
    end
    best = 2'd0;
    if (mag[0] < mag[1]) begin
      best = 2'd1;
    end
    if (mag[best] < mag[2]) begin
      best = 2'd2;
    end
    seen = (CMP_W'(mag[best]) >= CMP_W'(swing_threshold)) && (mag[best] >= peak_swing);
    code = seen ? {best, ~neg[best]} : '0;
    event_flag = seen && (!gesture_held || (held_code != code));
  end

  // indicator and tick counters
  always_comb begin
    led_pattern_next  = led_pattern;
    gesture_held_next = gesture_held;
    blink_level_next  = blink_level;
    blink_reload      = 1'b0;
    if (seen) begin
      led_pattern_next  = asgd_pkg::LED_W'(1) << best;
      gesture_held_next = 1'b1;
    end else if (gesture_held) begin
      if (ticks_since_gesture >= hold_ticks) begin
        led_pattern_next  = asgd_pkg::IDLE_LED;
        gesture_held_next = 1'b0;
      end
    end else if (ticks_since_blink >= blink_ticks) begin
      blink_level_next = !blink_level;
      led_pattern_next = blink_level_next ? asgd_pkg::IDLE_LED : '0;
      blink_reload     = 1'b1;
    end

    if (seen) begin
      ticks_since_gesture_next = asgd_pkg::CNT_W'(1);
    end else if (ticks_since_gesture < asgd_pkg::COUNT_MAX) begin
      ticks_since_gesture_next = ticks_since_gesture + asgd_pkg::CNT_W'(1);
    end else begin
      ticks_since_gesture_next = ticks_since_gesture;
    end

    if (blink_reload) begin
      ticks_since_blink_next = asgd_pkg::CNT_W'(1);
    end else if (ticks_since_blink < asgd_pkg::COUNT_MAX) begin
      ticks_since_blink_next = ticks_since_blink + asgd_pkg::CNT_W'(1);
    end else begin
      ticks_since_blink_next = ticks_since_blink;
    end
  end

  // sequencer and tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      window_primed       <= 1'b0;
      head                <= '0;
      fill_cnt            <= '0;
      rd_idx              <= '0;
      scan_start          <= '0;
      peak_swing          <= '0;
      gesture_held        <= 1'b0;
      held_code           <= '0;
      ticks_since_gesture <= '0;
      ticks_since_blink   <= asgd_pkg::BLINK_CNT_RST;
      blink_level         <= 1'b1;
      led_pattern         <= asgd_pkg::IDLE_LED;
      prior_buttons       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (smp.valid) begin
            fill_cnt <= '0;
            state    <= window_primed ? ST_SHIFT : ST_FILL;
          end
        end
        ST_FILL: begin
          fill_cnt <= fill_cnt + IDX_W'(1);
          if (fill_cnt == LAST_IDX) begin
            window_primed <= 1'b1;
            state         <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          head <= (head == LAST_IDX) ? '0 : head + IDX_W'(1);
          if (scan_start != '0) begin
            scan_start <= scan_start - IDX_W'(1);
            rd_idx     <= scan_start - IDX_W'(1);
          end else begin
            peak_swing <= '0;
            rd_idx     <= '0;
          end
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_idx == LAST_IDX) begin
            state <= ST_LAST;
          end else begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
        end
        ST_LAST: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (eval_go) begin
            if (seen) begin
              scan_start <= epos[best];
              peak_swing <= mag[best];
              held_code  <= code;
            end
            gesture_held        <= gesture_held_next;
            led_pattern         <= led_pattern_next;
            blink_level         <= blink_level_next;
            ticks_since_gesture <= ticks_since_gesture_next;
            ticks_since_blink   <= ticks_since_blink_next;
            prior_buttons       <= smp_buttons;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // capture of the accepted word
  always_ff @(posedge clk) begin
    if (smp.valid && smp.ready) begin
      smp_word    <= {smp.accel_z, smp.accel_y, smp.accel_x};
      smp_buttons <= smp.button_mask;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (eval_go) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (eval_go) begin
      res_seen    <= seen;
      res_event   <= event_flag;
      res_code    <= code;
      res_leds    <= led_pattern_next;
      res_bev     <= (smp_buttons != prior_buttons);
      res_buttons <= smp_buttons;
    end
  end

  // window pointers stay inside the window
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (head <= LAST_IDX) && (scan_start <= LAST_IDX))
    else $error("window pointer out of range");

  // a committed gesture is held with its code on the next cycle
  a_gesture_held: assert property (@(posedge clk) disable iff (rst)
    (eval_go && seen) |=> (gesture_held && (held_code == $past(code))))
    else $error("gesture not held after commit");

  // the scan never starts before the scan start
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx >= scan_start))
    else $error("scan index below scan start");

  // at most one axis bit, or only the idle bit, is lit
  a_leds: assert property (@(posedge clk) disable iff (rst)
    $onehot0(led_pattern))
    else $error("indicator pattern has several bits set");

endmodule

// ===== verif/tb_top.sv =====
// testbench: swing gesture detector checked word by word against an in-bench tracker
`timescale 1ns / 1ps
module tb_top;

  localparam int          DRAIN_CYCLES = asgd_pkg::WINDOW_DEF + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          MAX_PRINTS   = 40;

  typedef logic [asgd_pkg::SAMPLE_BITS_DEF-1:0] sample_t;

  typedef enum logic [asgd_pkg::CODE_W-1:0] {
    G_LEFT  = 3'd0,
    G_RIGHT = 3'd1,
    G_PUSH  = 3'd2,
    G_PULL  = 3'd3,
    G_UP    = 3'd4,
    G_DOWN  = 3'd5
  } gesture_t;

  typedef struct packed {
    logic [asgd_pkg::BTN_W-1:0]   buttons;
    sample_t [asgd_pkg::AXES-1:0] axis;
  } smp_word_t;

  typedef struct packed {
    logic                        seen;
    logic                        evt;
    gesture_t                    code;
    logic [asgd_pkg::LED_W-1:0]  leds;
    logic                        btn_evt;
    logic [asgd_pkg::BTN_W-1:0]  buttons;
  } gesture_result_t;

  logic clk = 1'b0;
  logic rst;

  asgd_in_if  smp_if ();
  asgd_out_if res_if ();
  asgd_cfg_if cfg_if ();

  accel_swing_gesture_detector DUT (
    .clk (clk),
    .rst (rst),
    .smp (smp_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker state: window, scan control, hold and blink timers
  sample_t                     win [asgd_pkg::WINDOW_DEF][asgd_pkg::AXES];
  bit                          primed        = 1'b0;
  logic [3:0]                  scan_from     = '0;
  logic [asgd_pkg::THR_W-1:0]  peak          = '0;
  bit                          held          = 1'b0;
  gesture_t                    held_code     = G_LEFT;
  logic [asgd_pkg::CNT_W-1:0]  since_gesture = '0;
  logic [asgd_pkg::CNT_W-1:0]  since_blink   = asgd_pkg::BLINK_CNT_RST;
  bit                          blink_lvl     = 1'b1;
  logic [asgd_pkg::LED_W-1:0]  leds_now      = asgd_pkg::IDLE_LED;
  logic [asgd_pkg::BTN_W-1:0]  last_buttons  = '0;
  logic [asgd_pkg::THR_W-1:0]  thr           = asgd_pkg::THRESHOLD_RST;
  logic [asgd_pkg::CNT_W-1:0]  hold_len      = asgd_pkg::HOLD_RST;
  logic [asgd_pkg::CNT_W-1:0]  blink_len     = asgd_pkg::BLINK_RST;

  gesture_result_t gesture_results_due[$];
  int              mismatches  = 0;
  int unsigned     cycle_count = 0;
  bit              calm        = 1'b0;
  int              gap_odds    = 0;
  sample_t         axis_now [asgd_pkg::AXES];
  logic [asgd_pkg::BTN_W-1:0] btn_now = '0;

  // advance the tracker by one sample word and return the word the block should send
  function automatic gesture_result_t track_gesture(input smp_word_t w);
    int unsigned      mag [asgd_pkg::AXES];
    int unsigned      endp [asgd_pkg::AXES];
    bit               neg [asgd_pkg::AXES];
    int               a, i, best;
    logic [asgd_pkg::SAMPLE_BITS_DEF:0] lo;
    sample_t          hi;
    int unsigned      lo_at, hi_at;
    gesture_t         code;
    gesture_result_t  r;
    r = '0;
    if (!primed) begin
      for (i = 0; i < asgd_pkg::WINDOW_DEF; i++)
        for (a = 0; a < asgd_pkg::AXES; a++) win[i][a] = w.axis[a];
      primed = 1'b1;
    end
    if (scan_from != 0) scan_from = scan_from - 1'b1;
    else peak = '0;
    // shift in the new sample
    for (i = 0; i < asgd_pkg::WINDOW_DEF - 1; i++)
      for (a = 0; a < asgd_pkg::AXES; a++) win[i][a] = win[i+1][a];
    for (a = 0; a < asgd_pkg::AXES; a++) win[asgd_pkg::WINDOW_DEF-1][a] = w.axis[a];
    // per-axis extremes from the scan start, earliest position wins ties
    for (a = 0; a < asgd_pkg::AXES; a++) begin
      lo = {1'b1, {asgd_pkg::SAMPLE_BITS_DEF{1'b0}}};
      hi = '0;
      lo_at = 0;
      hi_at = 0;
      for (i = int'(scan_from); i < asgd_pkg::WINDOW_DEF; i++) begin
        if ({1'b0, win[i][a]} < lo) begin
          lo = {1'b0, win[i][a]};
          lo_at = i;
        end
        if (win[i][a] > hi) begin
          hi = win[i][a];
          hi_at = i;
        end
      end
      mag[a]  = int'(hi) - int'(lo);
      neg[a]  = (lo_at > hi_at) && ({1'b0, hi} != lo);
      endp[a] = (lo_at <= hi_at) ? hi_at : lo_at;
    end
    best = 0;
    for (a = 1; a < asgd_pkg::AXES; a++)
      if (mag[best] < mag[a]) best = a;
    if (mag[best] >= thr && mag[best] >= peak) begin
      case (best)
        0:       code = neg[best] ? G_LEFT : G_RIGHT;
        1:       code = neg[best] ? G_PUSH : G_PULL;
        default: code = neg[best] ? G_UP : G_DOWN;
      endcase
      leds_now      = asgd_pkg::LED_W'(1 << best);
      scan_from     = 4'(endp[best]);
      peak          = asgd_pkg::THR_W'(mag[best]);
      r.evt         = !held || held_code != code;
      held          = 1'b1;
      held_code     = code;
      since_gesture = '0;
      r.seen        = 1'b1;
      r.code        = code;
    end else if (held) begin
      if (since_gesture >= hold_len) begin
        leds_now = asgd_pkg::IDLE_LED;
        held     = 1'b0;
      end
    end else if (since_blink >= blink_len) begin
      blink_lvl   = !blink_lvl;
      leds_now    = blink_lvl ? asgd_pkg::IDLE_LED : '0;
      since_blink = '0;
    end
    r.btn_evt    = (w.buttons != last_buttons);
    last_buttons = w.buttons;
    if (since_gesture < asgd_pkg::COUNT_MAX) since_gesture++;
    if (since_blink < asgd_pkg::COUNT_MAX) since_blink++;
    r.leds    = leds_now;
    r.buttons = w.buttons;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // compare each result word with the oldest pending prediction
  always @(posedge clk) begin : result_check
    gesture_result_t want;
    if (rst === 1'b0 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (gesture_results_due.size() == 0) begin
        report_mismatch("unexpected result word, valid", 1, 0);
      end else begin
        want = gesture_results_due.pop_front();
        if (res_if.gesture_seen !== want.seen)
          report_mismatch("gesture_seen", res_if.gesture_seen, want.seen);
        if (res_if.gesture_event !== want.evt)
          report_mismatch("gesture_event", res_if.gesture_event, want.evt);
        if (res_if.gesture_code !== want.code)
          report_mismatch("gesture_code", res_if.gesture_code, want.code);
        if (res_if.indicator_leds !== want.leds)
          report_mismatch("indicator_leds", res_if.indicator_leds, want.leds);
        if (res_if.button_event !== want.btn_evt)
          report_mismatch("button_event", res_if.button_event, want.btn_evt);
        if (res_if.buttons_now !== want.buttons)
          report_mismatch("buttons_now", res_if.buttons_now, want.buttons);
      end
    end
  end

  // result backpressure in short bursts, off in the closing phase
  initial begin : result_backpressure
    int stall_left;
    bit stalls_on;
    stall_left   = 0;
    stalls_on    = 1'b1;
    res_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) stalls_on = !stalls_on;
      if (calm) begin
        res_if.ready <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // send one sample word; called and returns at a falling edge
  task automatic send_sample(input sample_t x, input sample_t y, input sample_t z,
                             input logic [asgd_pkg::BTN_W-1:0] b);
    smp_word_t w;
    int        n;
    w.axis[0] = x;
    w.axis[1] = y;
    w.axis[2] = z;
    w.buttons = b;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      n = $urandom_range(1, 4);
      smp_if.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    smp_if.valid       <= 1'b1;
    smp_if.accel_x     <= x;
    smp_if.accel_y     <= y;
    smp_if.accel_z     <= z;
    smp_if.button_mask <= b;
    do @(posedge clk); while (smp_if.ready !== 1'b1);
    gesture_results_due.push_back(track_gesture(w));
    @(negedge clk);
  endtask

  // hold the sender off until every pending word has come back
  task automatic drain_results();
    smp_if.valid <= 1'b0;
    while (gesture_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input asgd_pkg::cfg_reg_t idx, input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= asgd_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      asgd_pkg::REG_SWING_THRESHOLD: thr       = asgd_pkg::THR_W'(value);
      asgd_pkg::REG_HOLD_TICKS:      hold_len  = asgd_pkg::CNT_W'(value);
      asgd_pkg::REG_BLINK_TICKS:     blink_len = asgd_pkg::CNT_W'(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input int thr_v, input int hold_v, input int blink_v);
    write_reg(asgd_pkg::REG_SWING_THRESHOLD, thr_v);
    write_reg(asgd_pkg::REG_HOLD_TICKS, hold_v);
    write_reg(asgd_pkg::REG_BLINK_TICKS, blink_v);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic sample_t nudge(input sample_t v);
    int t;
    t = int'(v) + $urandom_range(0, 16) - 8;
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return sample_t'(t);
  endfunction

  function automatic logic [asgd_pkg::BTN_W-1:0] next_buttons(
      input logic [asgd_pkg::BTN_W-1:0] b);
    case ($urandom_range(0, 9))
      0:       return asgd_pkg::BTN_W'($urandom_range(0, 2047));
      1, 2:    return b ^ (asgd_pkg::BTN_W'(1) << $urandom_range(0, asgd_pkg::BTN_W - 1));
      default: return b;
    endcase
  endfunction

  // ramp on one axis between two random levels, other axes jitter
  task automatic send_swing(output int sent);
    int a, b, len, amp, from, k, v;
    bit rising;
    a      = $urandom_range(0, asgd_pkg::AXES - 1);
    len    = $urandom_range(2, 8);
    amp    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(150, 1023);
    from   = $urandom_range(0, 1023 - amp);
    rising = $urandom_range(0, 1);
    for (k = 0; k < len; k++) begin
      v = rising ? from + amp * k / (len - 1) : from + amp - amp * k / (len - 1);
      for (b = 0; b < asgd_pkg::AXES; b++)
        axis_now[b] = (b == a) ? sample_t'(v) : nudge(axis_now[b]);
      btn_now = next_buttons(btn_now);
      send_sample(axis_now[0], axis_now[1], axis_now[2], btn_now);
    end
    sent = len;
  endtask

  // quiet stretch in which hold and blink timers can run out
  task automatic send_rest(output int sent);
    int b, len, k;
    len = $urandom_range(1, 20);
    for (k = 0; k < len; k++) begin
      for (b = 0; b < asgd_pkg::AXES; b++) axis_now[b] = nudge(axis_now[b]);
      btn_now = next_buttons(btn_now);
      send_sample(axis_now[0], axis_now[1], axis_now[2], btn_now);
    end
    sent = len;
  endtask

  // unrelated random words
  task automatic send_noise(output int sent);
    int b, len, k;
    len = $urandom_range(1, 3);
    for (k = 0; k < len; k++) begin
      for (b = 0; b < asgd_pkg::AXES; b++) axis_now[b] = sample_t'($urandom_range(0, 1023));
      btn_now = asgd_pkg::BTN_W'($urandom_range(0, 2047));
      send_sample(axis_now[0], axis_now[1], axis_now[2], btn_now);
    end
    sent = len;
  endtask

  // first word after reset fills the whole window
  task automatic test_first_word_fills_window();
    send_sample(10'd1023, 10'd1023, 10'd1023, 11'h7FF);
    send_sample(10'd1023, 10'd0, 10'd1023, 11'h000);
    send_sample(10'd0, 10'd1023, 10'd0, 11'h555);
  endtask

  // full-scale swings reach every gesture code in turn
  task automatic test_each_gesture();
    drain_results();
    set_regs(180, 15, 45);
    send_sample(10'd0, 10'd512, 10'd512, 11'h001);
    send_sample(10'd1023, 10'd512, 10'd512, 11'h002);
    send_sample(10'd0, 10'd512, 10'd512, 11'h004);
    send_sample(10'd0, 10'd0, 10'd512, 11'h008);
    send_sample(10'd0, 10'd1023, 10'd512, 11'h010);
    send_sample(10'd0, 10'd0, 10'd512, 11'h020);
    send_sample(10'd0, 10'd0, 10'd0, 11'h040);
    send_sample(10'd0, 10'd0, 10'd1023, 11'h080);
    send_sample(10'd0, 10'd0, 10'd0, 11'h100);
    send_sample(10'd0, 10'd0, 10'd0, 11'h600);
  endtask

  // zero swing counts as positive and repeats are suppressed; zero hold and blink times
  task automatic test_zero_hold_and_blink();
    drain_results();
    set_regs(0, 0, 0);
    repeat (4) send_sample(10'd300, 10'd300, 10'd300, 11'h2AA);
    drain_results();
    set_regs(1023, 0, 0);
    repeat (3) send_sample(10'd300, 10'd300, 10'd300, 11'h2AA);
    send_sample(10'd0, 10'd300, 10'd300, 11'h7FF);
    send_sample(10'd1023, 10'd300, 10'd300, 11'h000);
    send_sample(10'd1023, 10'd300, 10'd300, 11'h000);
  endtask

  // mostly well-formed swings with random content, plus rests and noise
  task automatic test_random_traffic(input int thr_v, input int hold_v, input int blink_v,
                                     input int quota, input bit pause_midway);
    int sent, n, pick;
    bit paused;
    drain_results();
    set_regs(thr_v, hold_v, blink_v);
    sent   = 0;
    paused = 1'b0;
    while (sent < quota) begin
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
      pick = $urandom_range(0, 9);
      if (pick < 6) send_swing(n);
      else if (pick < 8) send_rest(n);
      else send_noise(n);
      sent += n;
      if (pause_midway && !paused && sent >= quota / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  task automatic finish_run();
    drain_results();
    if (gesture_results_due.size() != 0)
      report_mismatch("results never returned", 0, gesture_results_due.size());
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  endtask

  // test sequence
  initial begin
    rst                = 1'b1;
    smp_if.valid       = 1'b0;
    smp_if.accel_x     = '0;
    smp_if.accel_y     = '0;
    smp_if.accel_z     = '0;
    smp_if.button_mask = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = asgd_pkg::REG_SWING_THRESHOLD;
    cfg_if.data        = '0;
    axis_now[0]        = 10'd512;
    axis_now[1]        = 10'd512;
    axis_now[2]        = 10'd512;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_first_word_fills_window();
    test_each_gesture();
    test_zero_hold_and_blink();
    test_random_traffic(1023, 255, 1, 150, 1'b0);
    test_random_traffic(0, 1, 255, 150, 1'b0);
    test_random_traffic($urandom_range(100, 300), $urandom_range(1, 255),
                        $urandom_range(1, 255), 350, 1'b0);
    test_random_traffic(180, 15, 45, 350, 1'b1);
    test_random_traffic($urandom_range(100, 300), $urandom_range(1, 30),
                        $urandom_range(1, 60), 350, 1'b0);
    calm = 1'b1;
    test_random_traffic($urandom_range(0, 1023), $urandom_range(1, 255),
                        $urandom_range(1, 255), 300, 1'b0);
    finish_run();
  end

endmodule
